// File: hw/rtl/phip_pkg.sv
// Shared types and constants for the plugin info header parser.
`timescale 1ns / 1ps
`default_nettype none
package phip_pkg;

  localparam int unsigned MAGIC_LEN = 20;
  localparam int unsigned MIN_LEN   = 25 + 2;
  localparam int unsigned CNT_W     = $clog2(MIN_LEN + 1);

  localparam logic [7:0] TAG_MARK      = 8'hff;
  localparam logic [7:0] TAG_VERSION   = 8'h01;
  localparam logic [7:0] TAG_FIRST_STR = 8'h0a;
  localparam logic [7:0] TAG_LAST_STR  = 8'h0c;

  localparam logic [1:0] CFG_HOST_MAJOR = 2'd0;
  localparam logic [1:0] CFG_HOST_MINOR = 2'd1;
  localparam logic [1:0] CFG_HOST_PATCH = 2'd2;
  localparam logic [1:0] CFG_HOST_BUILD = 2'd3;

  localparam logic [1:0] VERDICT_PLUGIN   = 2'd0;
  localparam logic [1:0] VERDICT_MANGLED  = 2'd1;
  localparam logic [1:0] VERDICT_DIFFER   = 2'd2;
  localparam logic [1:0] VERDICT_INCOMPAT = 2'd3;

  typedef struct packed {
    logic [7:0] major;
    logic [7:0] minor;
    logic [7:0] patch;
    logic       build_kind;
  } host_cfg_t;

  typedef struct packed {
    logic       verdict_valid;
    logic [1:0] verdict;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       string_begin;
    logic [1:0] string_kind;
    logic [7:0] string_length;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [CNT_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = 8'hff;
      5'd1:    b = 8'h00;
      5'd2:    b = 8'h4d;
      5'd3:    b = 8'h47;
      5'd4:    b = 8'h50;
      5'd5:    b = 8'h53;
      5'd6:    b = 8'h2d;
      5'd7:    b = 8'h50;
      5'd8:    b = 8'h4c;
      5'd9:    b = 8'h55;
      5'd10:   b = 8'h47;
      5'd11:   b = 8'h49;
      5'd12:   b = 8'h4e;
      5'd13:   b = 8'h2d;
      5'd14:   b = 8'h49;
      5'd15:   b = 8'h4e;
      5'd16:   b = 8'h46;
      5'd17:   b = 8'h4f;
      5'd18:   b = 8'h3a;
      5'd19:   b = 8'hff;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/phip_in_stage.sv
// Input register stage for blob bytes.
`timescale 1ns / 1ps
`default_nettype none
module phip_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            last_o
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  assign in_tready = !valid_r || take_i;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !take_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign valid_o = valid_r;
  assign byte_o  = byte_r;
  assign last_o  = last_r;

endmodule
`default_nettype wire

// File: hw/rtl/phip_core.sv
// Blob parse state and per-byte result logic.
`timescale 1ns / 1ps
`default_nettype none
module phip_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic                last_i,
  input  wire phip_pkg::host_cfg_t host_i,
  output logic                     has_res_o,
  output phip_pkg::result_t        res_o
);
  import phip_pkg::*;

  localparam logic [3:0] PH_MAGIC = 4'd0;
  localparam logic [3:0] PH_VTAG  = 4'd1;
  localparam logic [3:0] PH_MAJOR = 4'd2;
  localparam logic [3:0] PH_MINOR = 4'd3;
  localparam logic [3:0] PH_PATCH = 4'd4;
  localparam logic [3:0] PH_BUILD = 4'd5;
  localparam logic [3:0] PH_VMARK = 4'd6;
  localparam logic [3:0] PH_TAG   = 4'd7;
  localparam logic [3:0] PH_LEN   = 4'd8;
  localparam logic [3:0] PH_DATA  = 4'd9;
  localparam logic [3:0] PH_MARK  = 4'd10;
  localparam logic [3:0] PH_DONE  = 4'd11;

  localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(MIN_LEN);
  localparam logic [CNT_W-1:0] CNT_MAGIC = CNT_W'(MAGIC_LEN - 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       phase_r, phase_nxt;
  logic [2:0]       pend_r, pend_nxt;
  logic             sent_r, sent_nxt;
  logic [7:0]       pmaj_r, pmaj_nxt;
  logic [7:0]       pmin_r, pmin_nxt;
  logic [7:0]       ppat_r, ppat_nxt;
  logic [7:0]       tag_r, tag_nxt;
  logic [7:0]       left_r, left_nxt;
  logic             decide;
  logic [1:0]       dec_v;
  logic             known;
  logic [7:0]       left_dec;
  result_t          res;

  assign known    = (tag_r >= TAG_FIRST_STR) && (tag_r <= TAG_LAST_STR);
  assign left_dec = left_r - 8'd1;

  always_comb begin
    cnt_nxt   = (cnt_r < CNT_MIN) ? cnt_r + CNT_W'(1) : cnt_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    sent_nxt  = sent_r;
    pmaj_nxt  = pmaj_r;
    pmin_nxt  = pmin_r;
    ppat_nxt  = ppat_r;
    tag_nxt   = tag_r;
    left_nxt  = left_r;
    decide    = 1'b0;
    dec_v     = VERDICT_MANGLED;
    res       = '0;

    if (!sent_r) begin
      unique case (phase_r)
        PH_MAGIC: begin
          if (byte_i != magic_byte(cnt_r)) begin
            decide = 1'b1;
          end else if (cnt_r >= CNT_MAGIC) begin
            phase_nxt = PH_VTAG;
          end
        end
        PH_VTAG: begin
          if (byte_i != TAG_VERSION) decide = 1'b1;
          else phase_nxt = PH_MAJOR;
        end
        PH_MAJOR: begin
          pmaj_nxt  = byte_i;
          phase_nxt = PH_MINOR;
        end
        PH_MINOR: begin
          pmin_nxt  = byte_i;
          phase_nxt = PH_PATCH;
        end
        PH_PATCH: begin
          ppat_nxt  = byte_i;
          phase_nxt = PH_BUILD;
        end
        PH_BUILD: begin
          if (byte_i != {7'd0, host_i.build_kind}) begin
            decide = 1'b1;
            dec_v  = VERDICT_DIFFER;
          end else if (host_i.major == 8'd0) begin
            if (pmaj_r != 8'd0 || pmin_r != host_i.minor || ppat_r != host_i.patch) begin
              decide = 1'b1;
              dec_v  = VERDICT_INCOMPAT;
            end else begin
              phase_nxt = PH_VMARK;
            end
          end else if (pmaj_r != host_i.major || pmin_r > host_i.minor) begin
            decide = 1'b1;
            dec_v  = VERDICT_INCOMPAT;
          end else begin
            phase_nxt = PH_VMARK;
          end
        end
        PH_VMARK, PH_MARK: begin
          if (byte_i != TAG_MARK) decide = 1'b1;
          else phase_nxt = PH_TAG;
        end
        PH_TAG: begin
          if (byte_i == TAG_MARK) begin
            decide = 1'b1;
            dec_v  = VERDICT_PLUGIN;
          end else if (byte_i < TAG_FIRST_STR) begin
            decide = 1'b1;
          end else begin
            tag_nxt   = byte_i;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          left_nxt = byte_i;
          if (known) begin
            res.string_begin  = 1'b1;
            res.string_kind   = 2'(tag_r - TAG_FIRST_STR);
            res.string_length = byte_i;
          end
          phase_nxt = (byte_i != 8'd0) ? PH_DATA : PH_MARK;
        end
        PH_DATA: begin
          if (known) begin
            res.payload_valid = 1'b1;
            res.payload_byte  = byte_i;
          end
          left_nxt = left_dec;
          if (left_dec == 8'd0) phase_nxt = PH_MARK;
        end
        default: begin
        end
      endcase

      if (decide) begin
        pend_nxt  = {1'b0, dec_v} + 3'd1;
        phase_nxt = PH_DONE;
      end

      if (last_i) begin
        res.verdict_valid = 1'b1;
        res.verdict = (cnt_nxt < CNT_MIN || pend_nxt == 3'd0) ? VERDICT_MANGLED
                                                               : 2'(pend_nxt - 3'd1);
      end else if (pend_nxt != 3'd0 && cnt_nxt >= CNT_MIN) begin
        res.verdict_valid = 1'b1;
        res.verdict       = 2'(pend_nxt - 3'd1);
        sent_nxt          = 1'b1;
      end
    end

    if (last_i) begin
      cnt_nxt   = '0;
      phase_nxt = PH_MAGIC;
      pend_nxt  = 3'd0;
      sent_nxt  = 1'b0;
      pmaj_nxt  = 8'd0;
      pmin_nxt  = 8'd0;
      ppat_nxt  = 8'd0;
      tag_nxt   = 8'd0;
      left_nxt  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= PH_MAGIC;
      pend_r  <= 3'd0;
      sent_r  <= 1'b0;
      pmaj_r  <= 8'd0;
      pmin_r  <= 8'd0;
      ppat_r  <= 8'd0;
      tag_r   <= 8'd0;
      left_r  <= 8'd0;
    end else if (step_i) begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      sent_r  <= sent_nxt;
      pmaj_r  <= pmaj_nxt;
      pmin_r  <= pmin_nxt;
      ppat_r  <= ppat_nxt;
      tag_r   <= tag_nxt;
      left_r  <= left_nxt;
    end
  end

  assign has_res_o = res.string_begin || res.payload_valid || res.verdict_valid;
  assign res_o     = res;

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && last_i |=> cnt_r == '0 && phase_r == PH_MAGIC && !sent_r)
    else $error("blob state not cleared after last byte");
  a_pend_done: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 3'd0 |-> phase_r == PH_DONE)
    else $error("pending verdict outside done phase");
  a_sent_pend: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r |-> pend_r != 3'd0 && cnt_r == CNT_MIN)
    else $error("verdict sent without decision or before minimum length");
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.string_begin && res.payload_valid))
    else $error("string begin and payload in one result");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/plugin_info_header_parser_top.sv
// Top level of the plugin info header parser.
//
// Input stream: one blob byte per transaction on in_tdata, in_tlast on the
// final byte of the blob. Output stream: at most one result transaction per
// input byte, carrying a string start, a string character and/or the
// blob verdict. Bytes that cause no result produce no output transaction.
// The user must write the host version registers through cfg_wr_en/cfg_addr/
// cfg_wdata only while the block is idle; the block itself does not enforce it.
// Path: a byte accepted into the input register passes through the parse
// step and its result is held in the result register that drives out_tvalid.
// Throughput is one byte per cycle while out_tready does not stall the output.
// Reset (rst_n low, synchronous) clears the parse state, empties both
// registers and loads host registers with major/minor/patch 0, build 1.
// When out_tready is low a held result stays; at most one more byte is
// taken into the input register, then in_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module plugin_info_header_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // string_length, payload_byte, verdict, zero pad
  output logic [4:0]       out_tuser,  // string_begin, string_kind, payload_valid, verdict_valid
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);
  import phip_pkg::*;

  host_cfg_t  host_r;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       take;
  logic       has_res;
  result_t    res;
  logic       out_valid_r;
  result_t    out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_r.major      <= 8'd0;
      host_r.minor      <= 8'd0;
      host_r.patch      <= 8'd0;
      host_r.build_kind <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_HOST_MAJOR: host_r.major      <= cfg_wdata;
        CFG_HOST_MINOR: host_r.minor      <= cfg_wdata;
        CFG_HOST_PATCH: host_r.patch      <= cfg_wdata;
        CFG_HOST_BUILD: host_r.build_kind <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign take = s1_valid && (!out_valid_r || out_tready);

  phip_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .take_i    (take),
    .valid_o   (s1_valid),
    .byte_o    (s1_byte),
    .last_o    (s1_last)
  );

  phip_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (take),
    .byte_i    (s1_byte),
    .last_i    (s1_last),
    .host_i    (host_r),
    .has_res_o (has_res),
    .res_o     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= has_res;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_res) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.verdict, out_res_r.payload_byte,
                       out_res_r.string_length};
  assign out_tuser  = {out_res_r.verdict_valid, out_res_r.payload_valid,
                       out_res_r.string_kind, out_res_r.string_begin};

endmodule
`default_nettype wire
